FILE: rtl/ffba_pkg.sv
// Package for the first-fit block allocator: pool geometry, widths,
// operation and status codes, and the sequencer state type.
// No dependencies.
package ffba_pkg;

  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 1024;

  localparam int BLK_LOG = $clog2(BLOCK_BYTES);
  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = 7;
  localparam int NEED_W  = 18;
  localparam int ADDR_W  = 32;
  localparam int REQ_W   = 17;
  localparam int PADDR_W = 3;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic REG_BASE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } state_t;

endpackage

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit contiguous block allocator, top level.
// Depends on ffba_pkg for geometry, codes and the state type.
//
// Usage: one request item enters on the in_ channel (in_valid, in_stall)
// and yields exactly one result item on the out_ channel (out_valid,
// out_stall). Allocate rounds request_bytes up to whole blocks (at least
// one) and claims the lowest free run that is long enough; free releases
// the run that starts at free_address; any other code only reports counts.
// Two pointers walk the used/head bitmaps one block per cycle: idx_r for
// the scan, k_r for marking a run on allocate and releasing one on free;
// report does no walk. The result item is registered as the block returns
// to idle, so the next item can be taken while that result is shown.
// in_stall is high while an item is being worked on. The result register
// sits apart from the input, so a new item may be taken while the last
// result waits under out_stall; a finished item then holds until the
// result register frees up. Reset (rst_n low, synchronous) marks all
// blocks free, clears the run heads and sets base_address to 0.
// The user writes base_address over the APB port only while the block is idle; the block does not enforce it.
module first_fit_block_allocator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [ffba_pkg::REQ_W-1:0]    in_request_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]   in_free_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [ffba_pkg::ADDR_W-1:0]   out_block_address,
  output logic [ffba_pkg::CNT_W-1:0]    out_blocks_free,
  output logic [ffba_pkg::CNT_W-1:0]    out_blocks_used,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ffba_pkg::*;

  state_t state_r, state_nxt;

  logic [NUM_BLOCKS-1:0] used_r, used_nxt;
  logic [NUM_BLOCKS-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [ADDR_W-1:0]     base_r;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [IDX_W:0]   k_r, k_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] need_r, need_nxt;
  logic [1:0]       st_r, st_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]  out_free_r, out_free_nxt;
  logic [CNT_W-1:0]  out_used_r, out_used_nxt;

  logic              in_acc;
  logic              res_slot;
  logic [NEED_W-1:0] need_raw;
  logic [NEED_W-1:0] need_fix;
  logic [ADDR_W-1:0] free_off;
  logic [ADDR_W-1:0] free_blk;
  logic [IDX_W-1:0]  free_idx;
  logic              free_ok;
  logic [CNT_W-1:0]  len_inc;
  logic [IDX_W-1:0]  run_start;
  logic              k_end;
  logic [IDX_W-1:0]  k_idx;
  logic              walk_stop;

  assign in_acc   = in_valid && !in_stall;
  assign res_slot = !out_valid_r || !out_stall;

  // request size in blocks, zero bytes counts as one block
  assign need_raw = ({1'b0, in_request_bytes} + NEED_W'(BLOCK_BYTES - 1)) >> BLK_LOG;
  assign need_fix = (need_raw == '0) ? NEED_W'(1) : need_raw;

  assign free_off = in_free_address - base_r;
  assign free_blk = free_off >> BLK_LOG;
  assign free_idx = free_blk[IDX_W-1:0];
  assign free_ok  = ((free_off & ADDR_W'(BLOCK_BYTES - 1)) == '0)
                    && (free_blk < ADDR_W'(NUM_BLOCKS))
                    && head_r[free_idx];

  assign len_inc   = len_r + CNT_W'(1);
  assign run_start = (len_r == '0) ? idx_r : start_r;

  assign k_idx     = k_r[IDX_W-1:0];
  assign k_end     = (k_r == (IDX_W+1)'(NUM_BLOCKS));
  assign walk_stop = k_end || !used_r[k_idx] || head_r[k_idx];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_operation == OP_ALLOC) begin
            if (need_fix > NEED_W'(NUM_BLOCKS)) state_nxt = S_DONE;
            else state_nxt = S_SCAN;
          end else if (in_operation == OP_FREE) begin
            state_nxt = free_ok ? S_FREE : S_DONE;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (!used_r[idx_r] && (len_inc == need_r)) state_nxt = S_MARK;
        else if (idx_r == IDX_W'(NUM_BLOCKS - 1)) state_nxt = S_DONE;
      end
      S_MARK: begin
        if (k_idx == end_r) state_nxt = S_DONE;
      end
      S_FREE: begin
        if (walk_stop) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_slot) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    used_nxt      = used_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    need_nxt      = need_r;
    st_nxt        = st_r;
    addr_nxt      = addr_r;
    out_status_nxt = out_status_r;
    out_addr_nxt  = out_addr_r;
    out_free_nxt  = out_free_r;
    out_used_nxt  = out_used_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt   = ST_OK;
          addr_nxt = '0;
          idx_nxt  = '0;
          len_nxt  = '0;
          need_nxt = need_fix[CNT_W-1:0];
          if (in_operation == OP_ALLOC) begin
            if (need_fix > NEED_W'(NUM_BLOCKS)) st_nxt = ST_NOFIT;
          end else if (in_operation == OP_FREE) begin
            if (free_ok) begin
              head_nxt[free_idx] = 1'b0;
              used_nxt[free_idx] = 1'b0;
              cnt_nxt = cnt_r - CNT_W'(1);
              k_nxt   = {1'b0, free_idx} + (IDX_W+1)'(1);
            end else begin
              st_nxt = ST_BADFREE;
            end
          end
        end
      end
      S_SCAN: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (used_r[idx_r]) begin
          len_nxt = '0;
          if (idx_r == IDX_W'(NUM_BLOCKS - 1)) st_nxt = ST_NOFIT;
        end else begin
          start_nxt = run_start;
          len_nxt   = len_inc;
          if (len_inc == need_r) begin
            head_nxt[run_start] = 1'b1;
            k_nxt   = {1'b0, run_start};
            end_nxt = idx_r;
          end else if (idx_r == IDX_W'(NUM_BLOCKS - 1)) begin
            st_nxt = ST_NOFIT;
          end
        end
      end
      S_MARK: begin
        used_nxt[k_idx] = 1'b1;
        cnt_nxt = cnt_r + CNT_W'(1);
        k_nxt   = k_r + (IDX_W+1)'(1);
        if (k_idx == end_r) begin
          addr_nxt = base_r + (ADDR_W'(start_r) << BLK_LOG);
        end
      end
      S_FREE: begin
        if (!walk_stop) begin
          used_nxt[k_idx] = 1'b0;
          cnt_nxt = cnt_r - CNT_W'(1);
          k_nxt   = k_r + (IDX_W+1)'(1);
        end
      end
      S_DONE: begin
        if (res_slot) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_addr_nxt   = addr_r;
          out_used_nxt   = cnt_r;
          out_free_nxt   = CNT_W'(NUM_BLOCKS) - cnt_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (psel && penable && pwrite && pready && (paddr[2] == REG_BASE)) begin
        base_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    k_r          <= k_nxt;
    len_r        <= len_nxt;
    need_r       <= need_nxt;
    st_r         <= st_nxt;
    addr_r       <= addr_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_free_r   <= out_free_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_blocks_free   = out_free_r;
  assign out_blocks_used   = out_used_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE) ? base_r : '0;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for first_fit_block_allocator_core: a class-based
// scoreboard tracks the used/head bitmaps and predicts every result item.
// Depends on ffba_pkg and the RTL top level only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam logic [1:0] OP_REPORT = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;   // unused code, behaves as report
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_ITEMS = 320;
  localparam int CALM_ITEMS = 150;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  nfree;
    logic [CNT_W-1:0]  nused;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [NUM_BLOCKS-1:0] used_map;
    logic [NUM_BLOCKS-1:0] head_map;
    logic [ADDR_W-1:0]     base;
    alloc_result_t         pending[$];
    int                    errors;

    function new();
      used_map = '0;
      head_map = '0;
      base = '0;
      errors = 0;
    endfunction

    function void set_base(logic [ADDR_W-1:0] b);
      base = b;
    endfunction

    function int count_used();
      int n;
      n = 0;
      for (int i = 0; i < NUM_BLOCKS; i++) if (used_map[i]) n++;
      return n;
    endfunction

    function logic [ADDR_W-1:0] block_addr(int idx);
      return base + ADDR_W'(idx) * ADDR_W'(BLOCK_BYTES);
    endfunction

    // address of a random live run, or random noise when none is held
    function logic [ADDR_W-1:0] pick_head();
      int heads[$];
      for (int i = 0; i < NUM_BLOCKS; i++) if (head_map[i]) heads.push_back(i);
      if (heads.size() == 0) return $urandom;
      return block_addr(heads[$urandom_range(0, heads.size() - 1)]);
    endfunction

    function void note_request(logic [1:0] op, logic [REQ_W-1:0] bytes,
                               logic [ADDR_W-1:0] faddr);
      alloc_result_t r;
      int need;
      int start;
      int len;
      int idx;
      int used;
      logic [ADDR_W-1:0] off;
      r.status = ST_OK;
      r.addr = '0;
      if (op == OP_ALLOC) begin
        need = (int'(bytes) + BLOCK_BYTES - 1) / BLOCK_BYTES;
        if (need == 0) need = 1;
        r.status = ST_NOFIT;
        start = 0;
        len = 0;
        if (need <= NUM_BLOCKS) begin
          for (int i = 0; i < NUM_BLOCKS; i++) begin
            if (used_map[i]) begin
              len = 0;
            end else begin
              if (len == 0) start = i;
              len++;
              if (len == need) begin
                for (int k = start; k <= i; k++) used_map[k] = 1'b1;
                head_map[start] = 1'b1;
                r.status = ST_OK;
                r.addr = block_addr(start);
                break;
              end
            end
          end
        end
      end else if (op == OP_FREE) begin
        off = faddr - base;
        if (off % ADDR_W'(BLOCK_BYTES) != 0 ||
            off / ADDR_W'(BLOCK_BYTES) >= ADDR_W'(NUM_BLOCKS)) begin
          r.status = ST_BADFREE;
        end else begin
          idx = int'(off / ADDR_W'(BLOCK_BYTES));
          if (!head_map[idx]) begin
            r.status = ST_BADFREE;
          end else begin
            head_map[idx] = 1'b0;
            used_map[idx] = 1'b0;
            // run continues through used blocks up to the next head
            for (int k = idx + 1; k < NUM_BLOCKS; k++) begin
              if (!used_map[k] || head_map[k]) break;
              used_map[k] = 1'b0;
            end
          end
        end
      end
      used = count_used();
      r.nfree = CNT_W'(NUM_BLOCKS - used);
      r.nused = CNT_W'(used);
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, logic [ADDR_W-1:0] exp_v, logic [ADDR_W-1:0] got_v);
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
      errors++;
    endtask

    task check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result item", '0, ADDR_W'(got.status));
        return;
      end
      exp_r = pending.pop_front();
      if (got.status !== exp_r.status)
        report_mismatch("status", ADDR_W'(exp_r.status), ADDR_W'(got.status));
      if (got.addr !== exp_r.addr) report_mismatch("block_address", exp_r.addr, got.addr);
      if (got.nfree !== exp_r.nfree)
        report_mismatch("blocks_free", ADDR_W'(exp_r.nfree), ADDR_W'(got.nfree));
      if (got.nused !== exp_r.nused)
        report_mismatch("blocks_used", ADDR_W'(exp_r.nused), ADDR_W'(got.nused));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_operation;
  logic [REQ_W-1:0]    in_request_bytes;
  logic [ADDR_W-1:0]   in_free_address;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [ADDR_W-1:0]   out_block_address;
  logic [CNT_W-1:0]    out_blocks_free;
  logic [CNT_W-1:0]    out_blocks_used;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  alloc_scoreboard sb;
  bit calm;
  int stall_left;
  int idle_cycles;

  first_fit_block_allocator_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_request_bytes(in_request_bytes),
    .in_free_address(in_free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_block_address(out_block_address),
    .out_blocks_free(out_blocks_free), .out_blocks_used(out_blocks_used),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result({out_status, out_block_address, out_blocks_free, out_blocks_used});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("testbench failed");
          $finish;
        end
      end
    end
  end

  task send_item(logic [1:0] op, logic [REQ_W-1:0] bytes, logic [ADDR_W-1:0] faddr);
    in_valid <= 1'b1;
    in_operation <= op;
    in_request_bytes <= bytes;
    in_free_address <= faddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, bytes, faddr);
  endtask

  task sender_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_base(logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PADDR_W'(4 * int'(REG_BASE));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_base(value);
  endtask

  task random_item();
    int pick;
    int alloc_share;
    logic [REQ_W-1:0] bytes;
    logic [ADDR_W-1:0] faddr;
    pick = $urandom_range(0, 99);
    bytes = REQ_W'($urandom);
    faddr = $urandom;
    // lean toward frees when the pool is nearly full
    alloc_share = (sb.count_used() > 48) ? 25 : 50;
    if (pick < alloc_share) begin
      case ($urandom_range(0, 49))
        0:        bytes = REQ_W'($urandom_range(0, 131071));
        1, 2, 3:  bytes = REQ_W'($urandom_range(0, 65536));
        4, 5, 6, 7, 8, 9, 10, 11, 12: bytes = REQ_W'($urandom_range(0, 16384));
        default:  bytes = REQ_W'($urandom_range(0, 4096));
      endcase
      send_item(OP_ALLOC, bytes, faddr);
    end else if (pick < 88) begin
      send_item(OP_FREE, bytes, sb.pick_head());
    end else if (pick < 94) begin
      // half the time an aligned address inside the pool, mostly not a run start; else random
      if ($urandom_range(0, 1) == 0)
        faddr = sb.block_addr($urandom_range(0, NUM_BLOCKS - 1));
      send_item(OP_FREE, bytes, faddr);
    end else begin
      send_item($urandom_range(0, 1) ? OP_REPORT : OP_SPARE, bytes, faddr);
    end
  endtask

  initial begin
    logic [31:0] bases[6];
    sb = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_REPORT;
    in_request_bytes = '0;
    in_free_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset base of zero
    send_item(OP_REPORT, '0, '0);
    send_item(OP_SPARE, '1, '1);
    send_item(OP_ALLOC, 17'd0, '0);        // zero bytes takes one block
    send_item(OP_ALLOC, 17'd1, '0);
    send_item(OP_ALLOC, 17'd1024, '0);
    send_item(OP_ALLOC, 17'd1025, '0);     // rounds up to two blocks
    send_item(OP_ALLOC, 17'd65536, '0);    // whole pool, no fit now
    send_item(OP_ALLOC, 17'd131071, '0);   // beyond the pool
    send_item(OP_FREE, '0, 32'h0000_0800);
    send_item(OP_FREE, '0, 32'h0000_0800); // already freed
    sender_gap();
    send_item(OP_FREE, '0, 32'h0000_1000); // inside a run
    send_item(OP_FREE, '0, 32'h0000_0C01); // misaligned
    send_item(OP_FREE, '0, 32'h0001_0000); // past the last block
    send_item(OP_FREE, '0, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 17'd2048, '0);     // skips the one-block hole
    send_item(OP_ALLOC, 17'd1000, '0);     // fills the hole
    send_item(OP_FREE, '0, 32'h0000_0000);
    send_item(OP_FREE, '0, 32'h0000_0400);
    send_item(OP_FREE, '0, 32'h0000_0800);
    send_item(OP_FREE, '0, 32'h0000_0C00);
    send_item(OP_FREE, '0, 32'h0000_1400);
    send_item(OP_ALLOC, 17'd65536, '0);    // whole pool
    send_item(OP_ALLOC, 17'd0, '0);        // nothing free
    send_item(OP_FREE, '0, 32'h0000_0000);
    send_item(OP_REPORT, '0, '0);

    bases[0] = 32'hFFFF_FC00;              // second block wraps to zero
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = $urandom;
    bases[3] = 32'h8000_0000;
    bases[4] = $urandom;
    bases[5] = 32'h0000_0000;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_base(bases[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 5 && n == PHASE_ITEMS - CALM_ITEMS) calm = 1'b1;
        random_item();
        sender_gap();
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: first_fit_block_allocator_core.f
rtl/ffba_pkg.sv
rtl/first_fit_block_allocator_core.sv
tb/testbench.sv
